// ----- src/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types, codes and helpers for the block average palette match.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int MAX_TILES_DEF = 256;

  localparam int SUM_W   = 20;
  localparam int PIX_W   = 8;
  localparam int ENTRY_W = 3 * SUM_W;
  localparam int SQ_W    = 2 * SUM_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int IDX_W   = 8;

  typedef enum logic [1:0] {
    MODE_TILE  = 2'd0,
    MODE_BLOCK = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_MATCH  = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_STORED = 2'd2,
    STATUS_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
  } ctl_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [PIX_W-1:0] px);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - PIX_W){1'b0}}, px};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ----- src/block_average_palette_match.sv -----
// ----------------------------------------------------------------------------
// block_average_palette_match: one pixel beat per cycle while in_stall is low; a tile end answers next cycle.
// A block end scans the stored palette through the single RAM read port and the
// distance pipeline, with the input stalled until the result is loaded.
// Synchronous reset empties the palette and clears the sums; RAM is not swept.
// ----------------------------------------------------------------------------
module block_average_palette_match #(
  parameter int MAX_TILES = bpm_pkg::MAX_TILES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [bpm_pkg::PIX_W-1:0]     blue,
  input  logic [bpm_pkg::PIX_W-1:0]     green,
  input  logic [bpm_pkg::PIX_W-1:0]     red,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpm_pkg::IDX_W-1:0]     tile_index,
  output logic [1:0]                    status
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam int IW = (AW > bpm_pkg::IDX_W) ? AW : bpm_pkg::IDX_W;
  localparam int SW = bpm_pkg::SUM_W;

  bpm_pkg::state_t state, state_next;
  bpm_pkg::ctl_t   ctl;

  logic [SW-1:0] blue_sum, green_sum, red_sum;
  logic [SW-1:0] b_new, g_new, r_new;
  logic [CW-1:0] used;
  logic [CW-1:0] cnt;
  logic          accept, out_free, load, found, last_issue, full;
  logic          wr_en;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] best_index;
  logic          busy;
  logic [bpm_pkg::ENTRY_W-1:0] rd_data;
  logic [1:0]    res_status;
  logic [AW-1:0] res_index;

  assign out_free   = !out_valid || !out_stall;
  assign accept     = in_valid && !in_stall;
  assign b_new      = bpm_pkg::sat_add(blue_sum, blue);
  assign g_new      = bpm_pkg::sat_add(green_sum, green);
  assign r_new      = bpm_pkg::sat_add(red_sum, red);
  assign full       = !(used < CW'(MAX_TILES));
  assign last_issue = (cnt + CW'(1)) == used;
  assign found      = (state == bpm_pkg::ST_DRAIN) && !busy && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpm_pkg::ST_IDLE: begin
        if (accept && last && mode == bpm_pkg::MODE_BLOCK && used != '0) begin
          state_next = bpm_pkg::ST_ISSUE;
        end
      end
      bpm_pkg::ST_ISSUE: begin
        if (last_issue) begin
          state_next = bpm_pkg::ST_DRAIN;
        end
      end
      bpm_pkg::ST_DRAIN: begin
        if (found) begin
          state_next = bpm_pkg::ST_IDLE;
        end
      end
      default: state_next = bpm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != bpm_pkg::ST_IDLE) || !out_free;
    ctl.issue = (state == bpm_pkg::ST_ISSUE);
    ctl.start = (state == bpm_pkg::ST_IDLE) && (state_next == bpm_pkg::ST_ISSUE);
  end

  always_comb begin
    load       = 1'b0;
    wr_en      = 1'b0;
    res_status = bpm_pkg::STATUS_MATCH;
    res_index  = '0;
    if (found) begin
      load      = 1'b1;
      res_index = best_index;
    end else if (accept && last && mode == bpm_pkg::MODE_TILE) begin
      load = 1'b1;
      if (full) begin
        res_status = bpm_pkg::STATUS_FULL;
      end else begin
        wr_en      = 1'b1;
        res_status = bpm_pkg::STATUS_STORED;
        res_index  = used[AW-1:0];
      end
    end else if (accept && last && mode == bpm_pkg::MODE_BLOCK && used == '0) begin
      load       = 1'b1;
      res_status = bpm_pkg::STATUS_EMPTY;
    end
  end

  assign idx_ext = IW'(res_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpm_pkg::ST_IDLE;
      used      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      blue_sum  <= '0;
      green_sum <= '0;
      red_sum   <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.start) begin
        cnt <= '0;
      end else if (ctl.issue) begin
        cnt <= cnt + CW'(1);
      end
      if (wr_en) begin
        used <= used + CW'(1);
      end
      if (found) begin
        blue_sum  <= '0;
        green_sum <= '0;
        red_sum   <= '0;
      end else if (accept && mode == bpm_pkg::MODE_CLEAR) begin
        used      <= '0;
        blue_sum  <= '0;
        green_sum <= '0;
        red_sum   <= '0;
      end else if (accept && (mode == bpm_pkg::MODE_TILE || mode == bpm_pkg::MODE_BLOCK)) begin
        // hold block sums as the search query until the scan completes
        if (!last || mode == bpm_pkg::MODE_BLOCK && used != '0) begin
          blue_sum  <= b_new;
          green_sum <= g_new;
          red_sum   <= r_new;
        end else begin
          blue_sum  <= '0;
          green_sum <= '0;
          red_sum   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_index <= idx_ext[bpm_pkg::IDX_W-1:0];
      status     <= res_status;
    end
  end

  bpm_ram #(
    .DEPTH (MAX_TILES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (used[AW-1:0]),
    .wr_data ({b_new, g_new, r_new}),
    .rd_en   (ctl.issue),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  bpm_dist #(
    .AW (AW)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .index      (cnt[AW-1:0]),
    .entry      (rd_data),
    .q_blue     (blue_sum),
    .q_green    (green_sum),
    .q_red      (red_sum),
    .busy       (busy),
    .best_index (best_index)
  );

endmodule

// ----- src/bpm_ram.sv -----
// ----------------------------------------------------------------------------
// bpm_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int DEPTH = bpm_pkg::MAX_TILES_DEF,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [bpm_pkg::ENTRY_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [bpm_pkg::ENTRY_W-1:0]  rd_data
);

  logic [bpm_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/bpm_dist.sv -----
// ----------------------------------------------------------------------------
// bpm_dist
// Distance pipeline: absolute differences, squares, sum, running minimum.
// ----------------------------------------------------------------------------
module bpm_dist #(
  parameter int AW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpm_pkg::ctl_t                ctl,
  input  logic [AW-1:0]                index,
  input  logic [bpm_pkg::ENTRY_W-1:0]  entry,
  input  logic [bpm_pkg::SUM_W-1:0]    q_blue,
  input  logic [bpm_pkg::SUM_W-1:0]    q_green,
  input  logic [bpm_pkg::SUM_W-1:0]    q_red,
  output logic                         busy,
  output logic [AW-1:0]                best_index
);

  localparam int SW = bpm_pkg::SUM_W;

  logic                         v0, v1, v2, v3;
  logic [AW-1:0]                i0, i1, i2, i3;
  logic [SW-1:0]                d_b, d_g, d_r;
  logic [bpm_pkg::SQ_W-1:0]     sq_b, sq_g, sq_r;
  logic [bpm_pkg::DIST_W-1:0]   sq_total;
  logic                         best_set;
  logic [bpm_pkg::DIST_W-1:0]   best_dist;
  logic [SW-1:0]                e_b, e_g, e_r;

  assign e_b = entry[3*SW-1:2*SW];
  assign e_g = entry[2*SW-1:SW];
  assign e_r = entry[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      best_set <= 1'b0;
    end else begin
      v0 <= ctl.issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (ctl.start) begin
        best_set <= 1'b0;
      end else if (v3 && (!best_set || sq_total < best_dist)) begin
        best_set <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    i0 <= index;
    i1 <= i0;
    i2 <= i1;
    i3 <= i2;
    d_b <= (q_blue  > e_b) ? q_blue  - e_b : e_b - q_blue;
    d_g <= (q_green > e_g) ? q_green - e_g : e_g - q_green;
    d_r <= (q_red   > e_r) ? q_red   - e_r : e_r - q_red;
    sq_b <= bpm_pkg::SQ_W'(d_b) * bpm_pkg::SQ_W'(d_b);
    sq_g <= bpm_pkg::SQ_W'(d_g) * bpm_pkg::SQ_W'(d_g);
    sq_r <= bpm_pkg::SQ_W'(d_r) * bpm_pkg::SQ_W'(d_r);
    sq_total <= bpm_pkg::DIST_W'(sq_b) + bpm_pkg::DIST_W'(sq_g) + bpm_pkg::DIST_W'(sq_r);
    if (!ctl.start && v3 && (!best_set || sq_total < best_dist)) begin
      best_dist  <= sq_total;
      best_index <= i3;
    end
  end

  assign busy = v0 | v1 | v2 | v3;

endmodule

// ----- bench/block_average_palette_match_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_palette_match_tb
// Streams tile and block pixels into the palette matcher and holds a local
// model of the channel sums and the palette. Each expected tile index and
// status is queued when its beat is accepted. Each output beat is checked
// against the oldest queued entry. Directed cases come first: empty palette,
// ignored mode, ties, mixed modes, clear and full palette.
// Random traffic follows under four idle and stall settings.
// ----------------------------------------------------------------------------
module block_average_palette_match_tb;

  localparam int PALETTE_DEPTH = bpm_pkg::MAX_TILES_DEF;
  localparam int SUM_LIMIT     = (1 << bpm_pkg::SUM_W) - 1;
  localparam int DRAIN_CYCLES  = PALETTE_DEPTH + 40;
  localparam int PW            = bpm_pkg::PIX_W;

  typedef struct packed {
    logic [bpm_pkg::IDX_W-1:0] tile_index;
    bpm_pkg::status_t          status;
  } palette_result_t;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [1:0]                mode      = bpm_pkg::MODE_NONE;
  logic [PW-1:0]             blue      = '0;
  logic [PW-1:0]             green     = '0;
  logic [PW-1:0]             red       = '0;
  logic                      last      = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [bpm_pkg::IDX_W-1:0] tile_index;
  logic [1:0]                status;

  palette_result_t pending_results[$];
  palette_result_t oldest_result;
  int              mismatch_count = 0;
  int              pixels_sent    = 0;
  int              send_idle_pct  = 0;
  int              stall_pct      = 0;

  int sum_blue  = 0;
  int sum_green = 0;
  int sum_red   = 0;
  int pal_blue  [PALETTE_DEPTH];
  int pal_green [PALETTE_DEPTH];
  int pal_red   [PALETTE_DEPTH];
  int pal_count = 0;

  block_average_palette_match dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tile_index (tile_index),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("block_average_palette_match: mismatch");
    $finish;
  end

  function automatic int sat_sum(input int acc, input logic [PW-1:0] px);
    int s;
    s = acc + int'(px);
    return (s > SUM_LIMIT) ? SUM_LIMIT : s;
  endfunction

  function automatic longint unsigned sq_gap(input int a, input int b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic bit predict_pixel(input bpm_pkg::mode_t m, input logic [PW-1:0] b, g, r,
                                       input logic l, output palette_result_t res);
    longint unsigned gap_total;
    longint unsigned best_dist;
    int best;
    int i;
    res.tile_index = '0;
    res.status     = bpm_pkg::STATUS_MATCH;
    if (m == bpm_pkg::MODE_CLEAR) begin
      pal_count = 0;
      sum_blue  = 0;
      sum_green = 0;
      sum_red   = 0;
      return 1'b0;
    end
    if (m == bpm_pkg::MODE_NONE) return 1'b0;
    sum_blue  = sat_sum(sum_blue, b);
    sum_green = sat_sum(sum_green, g);
    sum_red   = sat_sum(sum_red, r);
    if (!l) return 1'b0;
    if (m == bpm_pkg::MODE_TILE) begin
      if (pal_count < PALETTE_DEPTH) begin
        pal_blue[pal_count]  = sum_blue;
        pal_green[pal_count] = sum_green;
        pal_red[pal_count]   = sum_red;
        res.tile_index = bpm_pkg::IDX_W'(pal_count);
        res.status     = bpm_pkg::STATUS_STORED;
        pal_count++;
      end else begin
        res.status = bpm_pkg::STATUS_FULL;
      end
    end else if (pal_count == 0) begin
      res.status = bpm_pkg::STATUS_EMPTY;
    end else begin
      best      = 0;
      best_dist = 0;
      for (i = 0; i < pal_count; i++) begin
        gap_total = sq_gap(sum_blue, pal_blue[i]) + sq_gap(sum_green, pal_green[i])
                  + sq_gap(sum_red, pal_red[i]);
        if (i == 0 || gap_total < best_dist) begin
          best_dist = gap_total;
          best      = i;
        end
      end
      res.tile_index = bpm_pkg::IDX_W'(best);
      res.status     = bpm_pkg::STATUS_MATCH;
    end
    sum_blue  = 0;
    sum_green = 0;
    sum_red   = 0;
    return 1'b1;
  endfunction

  function automatic logic [PW-1:0] pick_channel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return PW'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input bpm_pkg::mode_t m, input logic [PW-1:0] b, g, r,
                            input logic l);
    palette_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    blue     <= b;
    green    <= g;
    red      <= r;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_pixel(m, b, g, r, l, res)) pending_results = {pending_results, res};
    if (m != bpm_pkg::MODE_NONE) pixels_sent++;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tile_index %0d status %0d",
                                  tile_index, status));
      end else begin
        oldest_result = pending_results.pop_front();
        if (tile_index !== oldest_result.tile_index || status !== oldest_result.status)
          report_mismatch($sformatf("tile_index exp %0d got %0d, status exp %0d got %0d",
                                    oldest_result.tile_index, tile_index,
                                    oldest_result.status, status));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic test_empty_and_ignored();
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(bpm_pkg::MODE_NONE, 8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd7, 8'd8, 8'd9, 1'b0);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd0, 8'd0, 8'd0, 1'b1);
  endtask

  task automatic test_store_and_tie();
    send_pixel(bpm_pkg::MODE_TILE, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(bpm_pkg::MODE_TILE, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(bpm_pkg::MODE_TILE, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd128, 8'd127, 8'd128, 1'b1);
  endtask

  task automatic test_mixed_modes();
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(bpm_pkg::MODE_TILE, 8'd5, 8'd5, 8'd5, 1'b1);
    send_pixel(bpm_pkg::MODE_TILE, 8'd15, 8'd25, 8'd35, 1'b0);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd0, 8'd0, 8'd0, 1'b1);
  endtask

  task automatic test_clear();
    send_pixel(bpm_pkg::MODE_TILE, 8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(bpm_pkg::MODE_CLEAR, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(bpm_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(bpm_pkg::MODE_TILE, 8'd9, 8'd9, 8'd9, 1'b1);
  endtask

  task automatic test_full_palette();
    int i;
    send_pixel(bpm_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0);
    for (i = 0; i < PALETTE_DEPTH + 2; i++)
      send_pixel(bpm_pkg::MODE_TILE, PW'(i), PW'(255 - i), PW'(i * 37), 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd255, 8'd0, PW'(255 * 37), 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(bpm_pkg::MODE_BLOCK, 8'd130, 8'd120, 8'd60, 1'b1);
    send_pixel(bpm_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 1'b1);
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct, input int stall);
    int first;
    int len;
    int k;
    int r;
    bpm_pkg::mode_t m;
    bpm_pkg::mode_t other;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    first         = pixels_sent;
    while (pixels_sent - first < items) begin
      r = $urandom_range(99);
      if (r < 1) begin
        send_pixel(bpm_pkg::MODE_CLEAR, pick_channel(), pick_channel(), pick_channel(),
                   1'($urandom_range(1)));
      end else if (r < 4) begin
        send_pixel(bpm_pkg::MODE_NONE, pick_channel(), pick_channel(), pick_channel(),
                   1'($urandom_range(1)));
      end else if (r < 9) begin
        send_pixel(bpm_pkg::mode_t'($urandom_range(1)), pick_channel(), pick_channel(),
                   pick_channel(), 1'b0);
      end else begin
        m   = ($urandom_range(99) < 55) ? bpm_pkg::MODE_TILE : bpm_pkg::MODE_BLOCK;
        len = ($urandom_range(3) == 0) ? $urandom_range(8, 2) : $urandom_range(2, 1);
        for (k = 1; k <= len; k++) begin
          other = m;
          if (k < len && $urandom_range(9) == 0)
            other = (m == bpm_pkg::MODE_TILE) ? bpm_pkg::MODE_BLOCK : bpm_pkg::MODE_TILE;
          send_pixel(other, pick_channel(), pick_channel(), pick_channel(), k == len);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_ignored();
    test_store_and_tie();
    test_mixed_modes();
    test_clear();
    test_full_palette();
    test_random_traffic(192, 0, 0);
    test_random_traffic(192, 88, 0);
    test_random_traffic(192, 0, 88);
    test_random_traffic(192, 17, 17);
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("block_average_palette_match: match");
    end else begin
      $display("block_average_palette_match: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bpm_pkg.sv
src/bpm_ram.sv
src/bpm_dist.sv
src/block_average_palette_match.sv
bench/block_average_palette_match_tb.sv
